>>> hdl/fot_pkg.sv
// ============================================================================
// fot_pkg
// Shared types, sizes and helpers for the Fenwick order-statistic tree.
// ============================================================================
package fot_pkg;

    // Store geometry: positions 1..MAX_SIZE live at word address position-1
    localparam int MAX_SIZE = 1024;
    localparam int AW       = $clog2(MAX_SIZE);
    localparam int PW       = 11;   // position / size field width
    localparam int DW       = 32;   // count and sum width
    localparam int RW       = 31;   // rank width

    // Command codes
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_RANGE = 2'd1;
    localparam logic [1:0] CMD_FIND  = 2'd2;

    // Register map (byte addresses)
    localparam logic [1:0] REG_SIZE_IN_USE = 2'd0;
    localparam logic [PW-1:0] SIZE_RESET = PW'(MAX_SIZE);

    // One input item
    typedef struct packed {
        logic [1:0]         command;
        logic [PW-1:0]      position;
        logic [PW-1:0]      low_pos;
        logic signed [DW-1:0] delta;
        logic [RW-1:0]      rank;
    } t_req;

    // One result item
    typedef struct packed {
        logic signed [DW-1:0] range_sum;
        logic [PW-1:0]      found_pos;
    } t_res;

    // Lowest set bit of an index
    function automatic logic [PW-1:0] low_bit(input logic [PW-1:0] x);
        low_bit = x & (~x + PW'(1));
    endfunction

    // Largest power of two not above x (x is at least 1)
    function automatic logic [PW-1:0] top_bit(input logic [PW-1:0] x);
        logic [PW-1:0] r;
        r = '0;
        for (int b = 0; b < PW; b++) begin
            if (x[b]) begin
                r = PW'(1) << b;
            end
        end
        top_bit = r;
    endfunction

    // Size register clamped to 1..MAX_SIZE
    function automatic logic [PW-1:0] eff_size(input logic [PW-1:0] s);
        logic [PW-1:0] r;
        r = s;
        if (s == '0) begin
            r = PW'(1);
        end else if (s > PW'(MAX_SIZE)) begin
            r = PW'(MAX_SIZE);
        end
        eff_size = r;
    endfunction

endpackage

>>> hdl/fot_engine.sv
// ============================================================================
// fot_engine
// Tree store and the sequencer that walks it: one read per tree level for a
// range sum or a find, one read-modify-write per level for an add, and a clearing sweep after reset.
// ============================================================================
module fot_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  fot_pkg::t_req  i_req,
    input  logic [10:0]    i_size,
    output logic           o_idle,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output fot_pkg::t_res  o_res
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_ADD_RD   = 4'd2;
    localparam logic [3:0] S_ADD_WR   = 4'd3;
    localparam logic [3:0] S_PRE_RD   = 4'd4;
    localparam logic [3:0] S_PRE_ACC  = 4'd5;
    localparam logic [3:0] S_FIND_RD  = 4'd6;
    localparam logic [3:0] S_FIND_CMP = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    localparam int AW = fot_pkg::AW;
    localparam int PW = fot_pkg::PW;
    localparam int DW = fot_pkg::DW;
    localparam int RW = fot_pkg::RW;

    // Tree store
    logic [DW-1:0] mem [fot_pkg::MAX_SIZE];
    logic [DW-1:0] r_rdata;
    logic [AW-1:0] mem_raddr;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic          mem_we;

    // Sequencer state
    logic [3:0]     r_state,    n_state;
    logic [AW:0]    r_clr,      n_clr;
    logic [PW-1:0]  r_k,        n_k;      // add index, prefix index, find base
    logic [PW-1:0]  r_step,     n_step;
    logic [PW-1:0]  r_below,    n_below;
    logic [PW-1:0]  r_n,        n_n;
    logic           r_phase,    n_phase;  // range: second prefix subtracts
    logic [DW-1:0]  r_acc,      n_acc;
    logic [DW-1:0]  r_delta,    n_delta;
    logic [RW-1:0]  r_rank,     n_rank;
    fot_pkg::t_res  r_res,      n_res;

    logic [PW-1:0]  start_n;
    logic [PW:0]    add_next;
    logic [PW-1:0]  find_nxt;
    logic [PW-1:0]  step_half;
    logic [DW-1:0]  cand;
    logic [PW-1:0]  at_upd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    assign start_n   = fot_pkg::eff_size(i_size);
    assign add_next  = {1'b0, r_k} + {1'b0, fot_pkg::low_bit(r_k)};
    assign find_nxt  = r_k + r_step;
    assign step_half = r_step >> 1;
    assign cand      = r_acc + r_rdata;

    // Candidate accepted when wrapped signed sum is below rank
    always_comb begin
        at_upd = r_k;
        if ($signed(cand) < $signed({1'b0, r_rank})) begin
            at_upd = find_nxt;
        end
    end

    // Next state and memory control
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_k       = r_k;
        n_step    = r_step;
        n_below   = r_below;
        n_n       = r_n;
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_delta   = r_delta;
        n_rank    = r_rank;
        n_res     = r_res;
        mem_raddr = '0;
        mem_waddr = r_clr[AW-1:0];
        mem_wdata = '0;
        mem_we    = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_clr  = r_clr + 1'b1;
                if (r_clr == (AW+1)'(fot_pkg::MAX_SIZE - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_start) begin
                    n_n     = start_n;
                    n_delta = i_req.delta;
                    n_rank  = i_req.rank;
                    n_acc   = '0;
                    n_phase = 1'b0;
                    n_res   = '0;
                    n_state = S_DONE;
                    case (i_req.command)
                        fot_pkg::CMD_ADD: begin
                            if (i_req.position != '0 && i_req.position <= start_n) begin
                                n_k     = i_req.position;
                                n_state = S_ADD_RD;
                            end
                        end
                        fot_pkg::CMD_RANGE: begin
                            n_k = (i_req.position > start_n) ? start_n : i_req.position;
                            n_below = (i_req.low_pos == '0) ? '0 : i_req.low_pos - 1'b1;
                            n_state = S_PRE_RD;
                        end
                        fot_pkg::CMD_FIND: begin
                            if (i_req.rank == '0) begin
                                n_res.found_pos = PW'(1);
                            end else begin
                                n_k     = '0;
                                n_step  = fot_pkg::top_bit(start_n);
                                n_state = S_FIND_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Add: read word, then write it back with delta
            S_ADD_RD: begin
                mem_raddr = AW'(r_k - 1'b1);
                n_state   = S_ADD_WR;
            end

            S_ADD_WR: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_k - 1'b1);
                mem_wdata = r_rdata + r_delta;
                if (add_next <= {1'b0, r_n}) begin
                    n_k     = add_next[PW-1:0];
                    n_state = S_ADD_RD;
                end else begin
                    n_state = S_DONE;
                end
            end

            // Range: prefix(high) then minus prefix(low-1)
            S_PRE_RD: begin
                if (r_k != '0) begin
                    mem_raddr = AW'(r_k - 1'b1);
                    n_state   = S_PRE_ACC;
                end else if (!r_phase) begin
                    n_phase = 1'b1;
                    n_k     = (r_below > r_n) ? r_n : r_below;
                end else begin
                    n_res.range_sum = r_acc;
                    n_state         = S_DONE;
                end
            end

            S_PRE_ACC: begin
                n_acc   = r_phase ? (r_acc - r_rdata) : (r_acc + r_rdata);
                n_k     = r_k - fot_pkg::low_bit(r_k);
                n_state = S_PRE_RD;
            end

            // Find: binary descent, one level per read
            S_FIND_RD: begin
                if (find_nxt <= r_n) begin
                    mem_raddr = AW'(find_nxt - 1'b1);
                    n_state   = S_FIND_CMP;
                end else begin
                    n_step = step_half;
                    if (step_half == '0) begin
                        n_res.found_pos = r_k + 1'b1;
                        n_state         = S_DONE;
                    end
                end
            end

            S_FIND_CMP: begin
                if ($signed(cand) < $signed({1'b0, r_rank})) begin
                    n_acc = cand;
                end
                n_k    = at_upd;
                n_step = step_half;
                if (step_half == '0) begin
                    n_res.found_pos = at_upd + 1'b1;
                    n_state         = S_DONE;
                end else begin
                    n_state = S_FIND_RD;
                end
            end

            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_step  <= n_step;
        r_below <= n_below;
        r_n     <= n_n;
        r_phase <= n_phase;
        r_acc   <= n_acc;
        r_delta <= n_delta;
        r_rank  <= n_rank;
        r_res   <= n_res;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

>>> hdl/fenwick_order_statistic_tree.sv
// ============================================================================
// fenwick_order_statistic_tree
// Binary indexed tree of signed counts: add, range sum, k-th order search.
// ============================================================================
// One command is in the tree at a time. An add reads then writes back each
// tree level it touches; a range sum reads and accumulates each level of its
// two prefix walks; a find reads and compares on each descent level inside
// the size and only halves its step on the others. The pace is set by the
// single tree memory, whose registered read sits in every level of the walk.
// After reset the store is swept to zero, one word a cycle; no item is taken
// then, configuration writes are. Each result then passes through the output
// register, which holds it while the next command is accepted.
// ============================================================================
module fenwick_order_statistic_tree (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // position[10:0], low_pos[21:11],
                                       // delta[53:22], rank[84:54], zero pad
    input  logic [1:0]  s_axis_tuser,  // command[1:0]
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // range_sum[31:0], found_pos[42:32], pad
);

    logic [10:0]   r_size;
    logic          cfg_wr;
    fot_pkg::t_req req;
    fot_pkg::t_res eng_res;
    logic          eng_idle;
    logic          eng_res_valid;
    logic          res_ready;
    logic          in_beat;
    logic          r_out_valid;
    fot_pkg::t_res r_out;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= fot_pkg::SIZE_RESET;
        end else if (cfg_wr && paddr == fot_pkg::REG_SIZE_IN_USE) begin
            r_size <= pwdata[10:0];
        end
    end

    assign prdata = (paddr == fot_pkg::REG_SIZE_IN_USE) ? {21'b0, r_size} : 32'b0;

    // Input beat unpack
    assign req.command  = s_axis_tuser;
    assign req.position = s_axis_tdata[10:0];
    assign req.low_pos  = s_axis_tdata[21:11];
    assign req.delta    = s_axis_tdata[53:22];
    assign req.rank     = s_axis_tdata[84:54];

    assign s_axis_tready = eng_idle;
    assign in_beat       = s_axis_tvalid && eng_idle;

    fot_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_beat),
        .i_req       (req),
        .i_size      (r_size),
        .o_idle      (eng_idle),
        .o_res_valid (eng_res_valid),
        .i_res_ready (res_ready),
        .o_res       (eng_res)
    );

    // Output register
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= eng_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && eng_res_valid) begin
            r_out <= eng_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.found_pos, r_out.range_sum};

endmodule
